// ===== hw/rtl/yad_pkg.sv =====
// yad_pkg: shared types and constants for the YOLO anchor decoder.
// Used by yad_front, yad_queue, yad_back and yolo_anchor_decoder_unit.
`default_nettype none
package yad_pkg;

    localparam int MAX_CLASSES_DEF = 1024;
    localparam int CLASS_CAP       = 1024;
    localparam int POS_W           = 11;
    localparam int CLS_W           = 10;
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = 20;
    localparam int QUEUE_DEPTH     = 4;
    localparam int QPTR_W          = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W          = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LAYOUT_MODE = 3'd0,
        REG_CLASS_COUNT = 3'd1,
        REG_CONF_THR    = 3'd2,
        REG_SCALE_H     = 3'd3,
        REG_SCALE_V     = 3'd4,
        REG_ROI_LEFT    = 3'd5,
        REG_ROI_TOP     = 3'd6
    } t_yad_reg;

    typedef struct packed {
        logic        layout_mode;
        logic [10:0] class_count;
        logic [16:0] conf_threshold;
        logic [19:0] scale_horizontal;
        logic [19:0] scale_vertical;
        logic [15:0] roi_left;
        logic [15:0] roi_top;
    } t_yad_cfg;

    // one queued transaction: either a best-score clear or a class score
    typedef struct packed {
        logic             clear;
        logic             last;
        logic             rejected;
        logic             mode;
        logic [CLS_W-1:0] cls;
        logic [31:0]      value;
        logic [31:0]      objness;
        logic [31:0]      cx;
        logic [31:0]      cy;
        logic [31:0]      w;
        logic [31:0]      h;
    } t_yad_entry;

endpackage
`default_nettype wire

// ===== hw/rtl/yolo_anchor_decoder_unit.sv =====
// Top level of the YOLO anchor decoder: config registers, front, queue, back.
// Throughput: one tensor element per cycle; the front takes an element each
// cycle the 4-entry queue has room, the back drains one per cycle unless the
// output register is stalled. After it leaves the queue, the last class score
// passes the product, best compare, scale multiply and sums registers to the box.
// Reset (synchronous, active low) restores register defaults and empties state.
`default_nettype none
module yolo_anchor_decoder_unit #(
    parameter int MAX_CLASSES = yad_pkg::MAX_CLASSES_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // configuration write port
    input  wire logic                            i_cfg_we,
    input  wire logic [yad_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [yad_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    // element stream
    input  wire logic                            i_in_valid,
    output      logic                            o_in_ready,
    input  wire logic signed [31:0]              i_sample_value,
    input  wire logic                            i_first_of_anchor,
    // box stream
    output      logic                            o_out_valid,
    input  wire logic                            i_out_ready,
    output      logic signed [17:0]              o_box_x,
    output      logic signed [17:0]              o_box_y,
    output      logic signed [15:0]              o_box_width,
    output      logic signed [15:0]              o_box_height,
    output      logic [16:0]                     o_best_score,
    output      logic [9:0]                      o_class_index
);
    yad_pkg::t_yad_cfg   r_cfg;
    yad_pkg::t_yad_entry push_entry, head;
    logic                push, pop, full, empty, accept;

    // config registers, fields masked to their widths
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.layout_mode      <= 1'b0;
            r_cfg.class_count      <= 11'd80;
            r_cfg.conf_threshold   <= 17'd16384;
            r_cfg.scale_horizontal <= 20'd65536;
            r_cfg.scale_vertical   <= 20'd65536;
            r_cfg.roi_left         <= '0;
            r_cfg.roi_top          <= '0;
        end else if (i_cfg_we) begin
            unique case (yad_pkg::t_yad_reg'(i_cfg_idx))
                yad_pkg::REG_LAYOUT_MODE: r_cfg.layout_mode      <= i_cfg_data[0];
                yad_pkg::REG_CLASS_COUNT: r_cfg.class_count      <= i_cfg_data[10:0];
                yad_pkg::REG_CONF_THR:    r_cfg.conf_threshold   <= i_cfg_data[16:0];
                yad_pkg::REG_SCALE_H:     r_cfg.scale_horizontal <= i_cfg_data;
                yad_pkg::REG_SCALE_V:     r_cfg.scale_vertical   <= i_cfg_data;
                yad_pkg::REG_ROI_LEFT:    r_cfg.roi_left         <= i_cfg_data[15:0];
                yad_pkg::REG_ROI_TOP:     r_cfg.roi_top          <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // front keeps accepting while the queue has room
    assign o_in_ready = !full;
    assign accept     = i_in_valid && !full;

    yad_front #(.MAX_CLASSES(MAX_CLASSES)) u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg             (r_cfg),
        .i_accept          (accept),
        .i_sample_value    (i_sample_value),
        .i_first_of_anchor (i_first_of_anchor),
        .o_push            (push),
        .o_entry           (push_entry)
    );

    yad_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_head  (head)
    );

    yad_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_empty       (empty),
        .i_head        (head),
        .o_pop         (pop),
        .o_valid       (o_out_valid),
        .i_ready       (i_out_ready),
        .o_box_x       (o_box_x),
        .o_box_y       (o_box_y),
        .o_box_width   (o_box_width),
        .o_box_height  (o_box_height),
        .o_best_score  (o_best_score),
        .o_class_index (o_class_index)
    );
endmodule
`default_nettype wire

// ===== hw/rtl/yad_front.sv =====
// yad_front: element position tracking, header capture, objectness reject.
// Depends on yad_pkg; emits clear/score transactions toward yad_queue.
`default_nettype none
module yad_front #(
    parameter int MAX_CLASSES = yad_pkg::MAX_CLASSES_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire yad_pkg::t_yad_cfg i_cfg,
    input  wire logic              i_accept,
    input  wire logic [31:0]       i_sample_value,
    input  wire logic              i_first_of_anchor,
    output      logic              o_push,
    output      yad_pkg::t_yad_entry o_entry
);
    localparam int LIM = (MAX_CLASSES < yad_pkg::CLASS_CAP) ? MAX_CLASSES
                                                            : yad_pkg::CLASS_CAP;
    localparam logic [yad_pkg::POS_W-1:0] LIM_V = yad_pkg::POS_W'(LIM);

    logic [yad_pkg::POS_W-1:0] r_pos, pos, eff, first_score, last_pos;
    logic                      in_range, is_score;
    logic [31:0]               r_cx, r_cy, r_w, r_h, r_obj;
    logic                      r_rej;

    always_comb begin
        eff = i_cfg.class_count;
        if (eff == '0) eff = yad_pkg::POS_W'(1);
        if (eff > LIM_V) eff = LIM_V;
        first_score = i_cfg.layout_mode ? yad_pkg::POS_W'(4) : yad_pkg::POS_W'(5);
        last_pos    = first_score + eff - yad_pkg::POS_W'(1);
        pos         = i_first_of_anchor ? '0 : r_pos;
        in_range    = (pos <= last_pos);
        is_score    = (pos >= first_score);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
            r_rej <= 1'b0;
        end else if (i_accept && in_range) begin
            r_pos <= pos + yad_pkg::POS_W'(1);
            if (pos == '0) r_rej <= 1'b0;
            else if (pos >= yad_pkg::POS_W'(4) && !is_score)
                r_rej <= ($signed(i_sample_value) < $signed({15'd0, i_cfg.conf_threshold}));
        end
    end

    // header registers, cleared at reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cx  <= '0;
            r_cy  <= '0;
            r_w   <= '0;
            r_h   <= '0;
            r_obj <= '0;
        end else if (i_accept && in_range) begin
            unique case (pos)
                yad_pkg::POS_W'(0): r_cx <= i_sample_value;
                yad_pkg::POS_W'(1): r_cy <= i_sample_value;
                yad_pkg::POS_W'(2): r_w  <= i_sample_value;
                yad_pkg::POS_W'(3): r_h  <= i_sample_value;
                default: if (!is_score) r_obj <= i_sample_value;
            endcase
        end
    end

    always_comb begin
        o_push           = i_accept && in_range && (pos == '0 || is_score);
        o_entry.clear    = (pos == '0);
        o_entry.last     = (pos == last_pos);
        o_entry.rejected = r_rej;
        o_entry.mode     = i_cfg.layout_mode;
        o_entry.cls      = yad_pkg::CLS_W'(pos - first_score);
        o_entry.value    = i_sample_value;
        o_entry.objness  = r_obj;
        o_entry.cx       = r_cx;
        o_entry.cy       = r_cy;
        o_entry.w        = r_w;
        o_entry.h        = r_h;
    end
endmodule
`default_nettype wire

// ===== hw/rtl/yad_queue.sv =====
// yad_queue: small FIFO of transactions between front and back.
// Depends on yad_pkg for the entry type and depth.
`default_nettype none
module yad_queue (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_push,
    input  wire yad_pkg::t_yad_entry i_entry,
    input  wire logic                i_pop,
    output      logic                o_full,
    output      logic                o_empty,
    output      yad_pkg::t_yad_entry o_head
);
    yad_pkg::t_yad_entry          r_mem [yad_pkg::QUEUE_DEPTH];
    logic [yad_pkg::QPTR_W-1:0]   r_wp, r_rp;
    logic [yad_pkg::QCNT_W-1:0]   r_cnt;
    logic                         do_push, do_pop;

    assign o_full  = (r_cnt == yad_pkg::QCNT_W'(yad_pkg::QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wp] <= i_entry;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) r_wp <= r_wp + yad_pkg::QPTR_W'(1);
            if (do_pop)  r_rp <= r_rp + yad_pkg::QPTR_W'(1);
            r_cnt <= r_cnt + yad_pkg::QCNT_W'(do_push) - yad_pkg::QCNT_W'(do_pop);
        end
    end
endmodule
`default_nettype wire

// ===== hw/rtl/yad_back.sv =====
// yad_back: score multiply, running best, box scaling and output register.
// Depends on yad_pkg; pops transactions from yad_queue.
`default_nettype none
module yad_back (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire yad_pkg::t_yad_cfg   i_cfg,
    input  wire logic                i_empty,
    input  wire yad_pkg::t_yad_entry i_head,
    output      logic                o_pop,
    output      logic                o_valid,
    input  wire logic                i_ready,
    output      logic signed [17:0]  o_box_x,
    output      logic signed [17:0]  o_box_y,
    output      logic signed [15:0]  o_box_width,
    output      logic signed [15:0]  o_box_height,
    output      logic [16:0]         o_best_score,
    output      logic [9:0]          o_class_index
);
    logic                          en;
    // stage A: product
    logic                          r_a_valid;
    yad_pkg::t_yad_entry           r_a;
    logic signed [63:0]            r_a_prod;
    // running best
    logic [16:0]                   r_best;
    logic [yad_pkg::CLS_W-1:0]     r_best_cls;
    logic [16:0]                   s, nb;
    logic [yad_pkg::CLS_W-1:0]     ncls;
    logic                          emit;
    // stage B: box operands
    logic                          r_b_valid;
    logic [31:0]                   r_b_cx, r_b_cy, r_b_w, r_b_h;
    logic [16:0]                   r_b_score, r_c_score;
    logic [yad_pkg::CLS_W-1:0]     r_b_cls, r_c_cls;
    // stage C: scaled products
    logic                          r_c_valid;
    logic signed [52:0]            r_cxs, r_cys, r_ws, r_hs;
    // stage D: output
    logic                          r_out_valid;
    logic signed [17:0]            r_bx, r_by;
    logic signed [15:0]            r_bw, r_bh;
    logic [16:0]                   r_score;
    logic [yad_pkg::CLS_W-1:0]     r_cls;
    logic signed [54:0]            nx, ny;
    logic signed [21:0]            qx, qy;
    logic signed [22:0]            sx, sy;
    logic signed [20:0]            qw, qh;

    assign en    = !r_out_valid || i_ready;
    assign o_pop = en && !i_empty;

    // edge term: (2*c*s - w*s) / 2^33, toward zero
    function automatic logic signed [21:0] edge_q(input logic signed [54:0] n);
        logic signed [54:0] t;
        t = n[54] ? n + 55'sh1_FFFF_FFFF : n;
        return t[54:33];
    endfunction

    function automatic logic signed [20:0] size_q(input logic signed [52:0] n);
        logic signed [52:0] t;
        t = n[52] ? n + 53'sh0_FFFF_FFFF : n;
        return t[52:32];
    endfunction

    function automatic logic signed [17:0] sat18(input logic signed [22:0] v);
        if (v > 23'sd131071) return 18'sh1FFFF;
        if (v < -23'sd131072) return 18'sh20000;
        return v[17:0];
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [20:0] v);
        if (v > 21'sd32767) return 16'sh7FFF;
        if (v < -21'sd32768) return 16'sh8000;
        return v[15:0];
    endfunction

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a      <= i_head;
            r_a_prod <= $signed(i_head.objness) * $signed(i_head.value);
        end
    end

    always_comb begin
        if (r_a.mode == 1'b0) begin
            if (r_a_prod <= 64'sd0) s = '0;
            else if (r_a_prod[63:16] > 48'd65536) s = 17'd65536;
            else s = r_a_prod[32:16];
        end else begin
            if ($signed(r_a.value) < 32'sd0) s = '0;
            else if ($signed(r_a.value) > 32'sd65536) s = 17'd65536;
            else s = r_a.value[16:0];
        end
        if (s > r_best) begin
            nb   = s;
            ncls = r_a.cls;
        end else begin
            nb   = r_best;
            ncls = r_best_cls;
        end
        emit = r_a_valid && !r_a.clear && r_a.last && !r_a.rejected
               && (nb >= i_cfg.conf_threshold);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid   <= 1'b0;
            r_b_valid   <= 1'b0;
            r_c_valid   <= 1'b0;
            r_out_valid <= 1'b0;
            r_best      <= '0;
            r_best_cls  <= '0;
        end else begin
            if (en) begin
                r_a_valid <= !i_empty;
                r_b_valid <= emit;
                r_c_valid <= r_b_valid;
                r_out_valid <= r_c_valid;
                if (r_a_valid) begin
                    if (r_a.clear) begin
                        r_best     <= '0;
                        r_best_cls <= '0;
                    end else begin
                        r_best     <= nb;
                        r_best_cls <= ncls;
                    end
                end
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_b_cx    <= r_a.cx;
            r_b_cy    <= r_a.cy;
            r_b_w     <= r_a.w;
            r_b_h     <= r_a.h;
            r_b_score <= nb;
            r_b_cls   <= ncls;
            r_cxs     <= $signed(r_b_cx) * $signed({1'b0, i_cfg.scale_horizontal});
            r_ws      <= $signed(r_b_w)  * $signed({1'b0, i_cfg.scale_horizontal});
            r_cys     <= $signed(r_b_cy) * $signed({1'b0, i_cfg.scale_vertical});
            r_hs      <= $signed(r_b_h)  * $signed({1'b0, i_cfg.scale_vertical});
            r_c_score <= r_b_score;
            r_c_cls   <= r_b_cls;
            r_bx      <= sat18(sx);
            r_by      <= sat18(sy);
            r_bw      <= sat16(qw);
            r_bh      <= sat16(qh);
            r_score   <= r_c_score;
            r_cls     <= r_c_cls;
        end
    end

    always_comb begin
        nx = {r_cxs[52], r_cxs, 1'b0} - {{2{r_ws[52]}}, r_ws};
        ny = {r_cys[52], r_cys, 1'b0} - {{2{r_hs[52]}}, r_hs};
        qx = edge_q(nx);
        qy = edge_q(ny);
        sx = $signed({7'd0, i_cfg.roi_left}) + {qx[21], qx};
        sy = $signed({7'd0, i_cfg.roi_top})  + {qy[21], qy};
        qw = size_q(r_ws);
        qh = size_q(r_hs);
    end

    assign o_valid       = r_out_valid;
    assign o_box_x       = r_bx;
    assign o_box_y       = r_by;
    assign o_box_width   = r_bw;
    assign o_box_height  = r_bh;
    assign o_best_score  = r_score;
    assign o_class_index = r_cls;
endmodule
`default_nettype wire

// ===== tb/sv/tb.sv =====
// tb: self-checking testbench for yolo_anchor_decoder_unit.
// Streams anchor rows, predicts boxes in a scoreboard class; needs yad_pkg and the RTL.
`timescale 1ns / 100ps
`default_nettype none
module tb;

    // box fields as one packed record for queueing and compare
    typedef struct packed {
        logic signed [17:0] bx;
        logic signed [17:0] by;
        logic signed [15:0] bw;
        logic signed [15:0] bh;
        logic [16:0]        score;
        logic [9:0]         cls;
    } t_box;

    // Scoreboard: own copy of registers and anchor state, queue of pending boxes.
    class box_scoreboard;
        yad_pkg::t_yad_cfg cfg;
        int unsigned pos;
        logic [16:0] best_score;
        logic [9:0]  best_cls;
        longint      cx, cy, w, h, obj;
        bit          rejected;
        t_box        pending[$];
        int          errors;
        int          boxes_seen;

        function void reset_state();
            cfg.layout_mode      = 1'b0;
            cfg.class_count      = 11'd80;
            cfg.conf_threshold   = 17'd16384;
            cfg.scale_horizontal = 20'd65536;
            cfg.scale_vertical   = 20'd65536;
            cfg.roi_left         = '0;
            cfg.roi_top          = '0;
            pos = 0; best_score = '0; best_cls = '0;
            cx = 0; cy = 0; w = 0; h = 0; obj = 0; rejected = 0;
            pending.delete();
        endfunction

        function void write_reg(yad_pkg::t_yad_reg idx, logic [19:0] d);
            case (idx)
                yad_pkg::REG_LAYOUT_MODE: cfg.layout_mode      = d[0];
                yad_pkg::REG_CLASS_COUNT: cfg.class_count      = d[10:0];
                yad_pkg::REG_CONF_THR:    cfg.conf_threshold   = d[16:0];
                yad_pkg::REG_SCALE_H:     cfg.scale_horizontal = d;
                yad_pkg::REG_SCALE_V:     cfg.scale_vertical   = d;
                yad_pkg::REG_ROI_LEFT:    cfg.roi_left         = d[15:0];
                yad_pkg::REG_ROI_TOP:     cfg.roi_top          = d[15:0];
                default: ;
            endcase
        endfunction

        function longint clip(longint v, longint lo, longint hi);
            return v < lo ? lo : (v > hi ? hi : v);
        endfunction

        // note one accepted element, predict a box when the anchor completes
        function void note_element(logic signed [31:0] val, bit first);
            longint      v, p, s, cxs, cys, ws, hs;
            int unsigned fs, nc, last;
            t_box        b;
            v  = val;
            fs = cfg.layout_mode ? 4 : 5;
            nc = cfg.class_count;
            if (nc < 1) nc = 1;
            if (nc > 1024) nc = 1024;
            last = fs + nc - 1;
            if (first) pos = 0;
            if (pos > last) return;
            if (pos == 0) begin
                cx = v; best_score = '0; best_cls = '0; rejected = 0;
            end else if (pos == 1) cy = v;
            else if (pos == 2) w = v;
            else if (pos == 3) h = v;
            else if (pos < fs) begin
                obj = v;
                if (v < longint'(cfg.conf_threshold)) rejected = 1;
            end else begin
                if (cfg.layout_mode == 1'b0) begin
                    p = obj * v;
                    s = (p <= 0) ? 0 : clip(p >>> 16, 0, 65536);
                end else begin
                    s = clip(v, 0, 65536);
                end
                if (s > longint'(best_score)) begin
                    best_score = s[16:0];
                    best_cls   = 10'(pos - fs);
                end
                if (pos == last && !rejected && best_score >= cfg.conf_threshold) begin
                    cxs = cx * longint'(cfg.scale_horizontal);
                    cys = cy * longint'(cfg.scale_vertical);
                    ws  = w * longint'(cfg.scale_horizontal);
                    hs  = h * longint'(cfg.scale_vertical);
                    // division truncates toward zero, as needed
                    b.bx = 18'(clip(longint'(cfg.roi_left) + (2 * cxs - ws) / (64'sd1 <<< 33),
                                    -131072, 131071));
                    b.by = 18'(clip(longint'(cfg.roi_top) + (2 * cys - hs) / (64'sd1 <<< 33),
                                    -131072, 131071));
                    b.bw = 16'(clip(ws / (64'sd1 <<< 32), -32768, 32767));
                    b.bh = 16'(clip(hs / (64'sd1 <<< 32), -32768, 32767));
                    b.score = best_score;
                    b.cls   = best_cls;
                    pending.insert(pending.size(), b);
                end
            end
            pos = pos + 1;
        endfunction

        function void check_box(t_box got);
            t_box e;
            boxes_seen++;
            if (pending.size() == 0) begin
                $display("%0t: unexpected box x=%0d y=%0d", $time, got.bx, got.by);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (got.bx !== e.bx) begin
                $display("%0t: box_x exp %0d got %0d", $time, e.bx, got.bx); errors++;
            end
            if (got.by !== e.by) begin
                $display("%0t: box_y exp %0d got %0d", $time, e.by, got.by); errors++;
            end
            if (got.bw !== e.bw) begin
                $display("%0t: box_width exp %0d got %0d", $time, e.bw, got.bw); errors++;
            end
            if (got.bh !== e.bh) begin
                $display("%0t: box_height exp %0d got %0d", $time, e.bh, got.bh); errors++;
            end
            if (got.score !== e.score) begin
                $display("%0t: best_score exp %0d got %0d", $time, e.score, got.score);
                errors++;
            end
            if (got.cls !== e.cls) begin
                $display("%0t: class_index exp %0d got %0d", $time, e.cls, got.cls);
                errors++;
            end
        endfunction
    endclass

    localparam int LIMIT_CYCLES = 1500000;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_we = 1'b0;
    logic [2:0]         i_cfg_idx = '0;
    logic [19:0]        i_cfg_data = '0;
    logic               i_in_valid = 1'b0;
    logic               o_in_ready;
    logic signed [31:0] i_sample_value = '0;
    logic               i_first_of_anchor = 1'b0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    logic signed [17:0] o_box_x, o_box_y;
    logic signed [15:0] o_box_width, o_box_height;
    logic [16:0]        o_best_score;
    logic [9:0]         o_class_index;

    box_scoreboard sb = new();
    int  cycles = 0;
    int  elements_sent = 0;
    int  anchors_sent = 0;
    bit  hold_off = 1'b0;   // long receiver stall request
    bit  gaps_on  = 1'b1;   // random idling enable

    yolo_anchor_decoder_unit dut (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .i_in_valid, .o_in_ready, .i_sample_value, .i_first_of_anchor,
        .o_out_valid, .i_out_ready, .o_box_x, .o_box_y, .o_box_width,
        .o_box_height, .o_best_score, .o_class_index
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("yolo_anchor_decoder_unit regression: fail");
            $finish;
        end
    end

    // receiver: random stalls, long stall on request
    initial begin : receiver
        int wait_n;
        forever begin
            @(posedge i_clk);
            if (!i_rst_n) continue;
            if (hold_off) begin
                i_out_ready <= 1'b0;
                wait_n = 0;
                while (wait_n < 300) begin
                    @(posedge i_clk);
                    wait_n++;
                end
                hold_off = 1'b0;
            end
            wait_n = gaps_on ? ($urandom_range(0, 3) == 0 ? $urandom_range(0, 16) : 0) : 0;
            if (wait_n > 0) begin
                i_out_ready <= 1'b0;
                repeat (wait_n) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
        end
    end

    // result monitor, sampled at the edge
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            sb.check_box({o_box_x, o_box_y, o_box_width, o_box_height,
                          o_best_score, o_class_index});
    end

    // one input transaction; stays valid until accepted
    task automatic send_element(logic signed [31:0] v, bit first);
        int gap;
        gap = gaps_on ? ($urandom_range(0, 3) == 0 ? $urandom_range(0, 16) : 0) : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid        <= 1'b1;
        i_sample_value    <= v;
        i_first_of_anchor <= first;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        sb.note_element(v, first);
        elements_sent++;
    endtask

    task automatic stop_input();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // wait until every predicted box has come, then let the pipeline drain
    task automatic drain();
        stop_input();
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    // write enable stays high across a burst; set_config drops it
    task automatic write_reg(yad_pkg::t_yad_reg idx, logic [19:0] d);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= d;
        @(posedge i_clk);
        sb.write_reg(idx, d);
    endtask

    task automatic set_config(bit mode, int nc, int thr, int sh, int sv, int rl, int rt);
        write_reg(yad_pkg::REG_LAYOUT_MODE, 20'(mode));
        write_reg(yad_pkg::REG_CLASS_COUNT, 20'(nc));
        write_reg(yad_pkg::REG_CONF_THR, 20'(thr));
        write_reg(yad_pkg::REG_SCALE_H, 20'(sh));
        write_reg(yad_pkg::REG_SCALE_V, 20'(sv));
        write_reg(yad_pkg::REG_ROI_LEFT, 20'(rl));
        write_reg(yad_pkg::REG_ROI_TOP, 20'(rt));
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic signed [31:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return 32'sh7FFF_FFFF;
            2: return 32'sh8000_0000;
            default: return $signed($urandom_range(0, 640 << 16)) - (32 << 16);
        endcase
    endfunction

    function automatic logic signed [31:0] rand_score();
        case ($urandom_range(0, 7))
            0: return $urandom();
            1: return -$signed($urandom_range(0, 65536));
            2: return 32'sh0001_0000 + $urandom_range(0, 65536);
            default: return $urandom_range(0, 65536);
        endcase
    endfunction

    // one well-formed anchor with random content
    task automatic send_anchor(int nc_sent);
        bit m;
        m = sb.cfg.layout_mode;
        send_element(rand_coord(), 1'b1);
        send_element(rand_coord(), 1'b0);
        send_element(rand_coord(), 1'b0);
        send_element(rand_coord(), 1'b0);
        if (!m)
            send_element($urandom_range(0, 3) == 0 ? rand_score() :
                         $urandom_range(16384, 65536), 1'b0);
        for (int k = 0; k < nc_sent; k++)
            send_element(rand_score(), 1'b0);
        anchors_sent++;
    endtask

    initial begin : stimulus
        int nc, n;
        // reset, all inputs known from time zero
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        sb.reset_state();
        @(posedge i_clk);

        // directed: no mark at start, ties, extremes, trailing junk
        gaps_on = 1'b0;
        set_config(1'b1, 3, 0, 65536, 65536, 0, 0);
        send_element(32'sh0010_0000, 1'b0);   // taken as cx without a mark
        send_element(32'sh0020_0000, 1'b0);
        send_element(32'sh0004_0000, 1'b0);
        send_element(32'sh0006_0000, 1'b0);
        send_element(32'sh0000_8000, 1'b0);   // tie at class 0 and 1
        send_element(32'sh0000_8000, 1'b0);
        send_element(32'sh0000_4000, 1'b0);
        send_element(32'sh0005_0000, 1'b0);   // past the last score: ignored
        send_element(32'sh7FFF_FFFF, 1'b1);   // extreme coordinates
        send_element(32'sh8000_0000, 1'b0);
        send_element(32'sh7FFF_FFFF, 1'b0);
        send_element(32'sh8000_0000, 1'b0);
        send_element(32'sh8000_0000, 1'b0);   // negative score clamps to 0
        send_element(32'sh7FFF_FFFF, 1'b0);   // scores above 1.0 saturate
        send_element(32'sh0001_0001, 1'b0);
        drain();
        set_config(1'b0, 2, 65536, 1048575, 1048575, 65535, 65535);
        send_element(-32'sd1, 1'b1);
        send_element(32'sh7FFF_FFFF, 1'b0);
        send_element(32'sh8000_0000, 1'b0);
        send_element(32'sh7FFF_FFFF, 1'b0);
        send_element(32'sh0000_4000, 1'b0);   // objectness below threshold: rejected
        send_element(32'sh0001_0000, 1'b0);
        send_element(32'sh0001_0000, 1'b0);
        drain();
        gaps_on = 1'b1;

        // random phases across settings, extremes included
        for (int ph = 0; ph < 9; ph++) begin
            case (ph)
                0:  set_config(1'b0, 80, 16384, 65536, 65536, 0, 0);
                1:  set_config(1'b1, 1, 0, 0, 0, 65535, 65535);
                2:  set_config(1'b0, 0, 65536, 1048575, 1048575, 0, 65535);
                3:  set_config(1'b1, 2047, 60000, 32768, 98304, 100, 200);
                4:  set_config(1'b0, 7, 8000, 65536, 65536, 0, 0);
                6:  set_config(1'b1, 4, 0, 65536, 65536, 0, 0);  // every anchor boxes
                default: set_config($urandom_range(0, 1), $urandom_range(1, 12),
                                    $urandom_range(0, 65536), $urandom(),
                                    $urandom(), $urandom(), $urandom());
            endcase
            nc = sb.cfg.class_count;
            if (nc < 1) nc = 1;
            if (nc > 1024) nc = 1024;
            n = (nc > 80) ? 1 : 40 / (nc + 5) + 2;
            if (ph == 6) hold_off = 1'b1;     // block fills up and stalls input
            for (int a = 0; a < n; a++) begin
                if ($urandom_range(0, 9) == 0) begin
                    // noise: broken anchor or stray elements
                    for (int k = $urandom_range(1, 6); k > 0; k--)
                        send_element($urandom(), $urandom_range(0, 1));
                end else begin
                    send_anchor(nc);
                end
            end
            if (ph == 8) begin
                // sender pauses until all boxes are in
                stop_input();
                while (sb.pending.size() != 0) @(posedge i_clk);
            end
            drain();
        end
        // bulk random in small class counts until the item budget is spent
        set_config(1'b0, 3, 12000, 65536, 65536, 10, 20);
        while (elements_sent < 1550) begin
            if ($urandom_range(0, 40) == 0) begin
                drain();
                set_config($urandom_range(0, 1), $urandom_range(1, 6),
                           $urandom_range(0, 40000), $urandom(), $urandom(),
                           $urandom(), $urandom());
            end
            send_anchor(sb.cfg.class_count == 0 ? 1 : sb.cfg.class_count);
        end
        drain();

        $display("covered %0d elements in %0d anchors, %0d boxes checked",
                 elements_sent, anchors_sent, sb.boxes_seen);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("yolo_anchor_decoder_unit regression: pass");
        else
            $display("yolo_anchor_decoder_unit regression: fail");
        $finish;
    end
endmodule
`default_nettype wire
